FILE: rtl/c8alu_pkg.sv
package c8alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD8  = 5'd0,
    OP_SUB8  = 5'd1,
    OP_ADD16 = 5'd2,
    OP_RLC   = 5'd3,
    OP_RRC   = 5'd4,
    OP_RL    = 5'd5,
    OP_RR    = 5'd6,
    OP_SLA   = 5'd7,
    OP_SRA   = 5'd8,
    OP_SRL   = 5'd9,
    OP_SWAP  = 5'd10,
    OP_DEC8  = 5'd11,
    OP_DEC16 = 5'd12,
    OP_INC8  = 5'd13,
    OP_INC16 = 5'd14,
    OP_AND   = 5'd15,
    OP_OR    = 5'd16,
    OP_XOR   = 5'd17,
    OP_CPL   = 5'd18,
    OP_CP    = 5'd19,
    OP_DAA   = 5'd20,
    OP_SCF   = 5'd21,
    OP_CCF   = 5'd22,
    OP_BIT   = 5'd23,
    OP_RES   = 5'd24,
    OP_SET   = 5'd25
  } op_e;

  localparam logic [3:0] NibbleMax = 4'h9;
  localparam logic [7:0] ByteBcdMax = 8'h99;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [4:0]  op;
    logic [7:0]  acc;
    logic [15:0] target;
    logic [15:0] source;
    logic        cin;
    logic [2:0]  bit_index;
    flags_t      flags;
  } req_t;

  typedef struct packed {
    logic [15:0] result;
    flags_t      flags;
  } rsp_t;

endpackage

FILE: rtl/cpu8_alu_with_flags.sv
// chan | valid       | stall       | payload
// in   | in_valid_i  | in_stall_o  | op_i acc_i target_i source_i cin_i bit_index_i {z,n,h,c}_in_i
// out  | out_valid_o | out_stall_i | result_o z_out_o n_out_o h_out_o c_out_o
//
// Two register stages: input register, then ALU logic into the result register.
// One beat per cycle while out_stall_i is low.
// Reset clears both valid bits; payload registers are not reset.
// A stalled output holds its beat; the input stage still takes one beat while
// the result register waits, then in_stall_o rises.
module cpu8_alu_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  op_i,
  input  logic [7:0]  acc_i,
  input  logic [15:0] target_i,
  input  logic [15:0] source_i,
  input  logic        cin_i,
  input  logic [2:0]  bit_index_i,
  input  logic        z_in_i,
  input  logic        n_in_i,
  input  logic        h_in_i,
  input  logic        c_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_o,
  output logic        z_out_o,
  output logic        n_out_o,
  output logic        h_out_o,
  output logic        c_out_o
);

  logic            in_valid_q;
  c8alu_pkg::req_t req_q;
  logic            out_valid_q;
  c8alu_pkg::rsp_t rsp_q;
  c8alu_pkg::rsp_t rsp_d;
  logic            out_adv;
  logic            in_adv;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  c8alu_core u_core (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      req_q <= '{op: op_i, acc: acc_i, target: target_i, source: source_i,
                 cin: cin_i, bit_index: bit_index_i,
                 flags: '{z: z_in_i, n: n_in_i, h: h_in_i, c: c_in_i}};
    end
    if (out_adv && in_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = rsp_q.result;
  assign z_out_o     = rsp_q.flags.z;
  assign n_out_o     = rsp_q.flags.n;
  assign h_out_o     = rsp_q.flags.h;
  assign c_out_o     = rsp_q.flags.c;

endmodule

FILE: rtl/c8alu_core.sv
module c8alu_core (
  input  c8alu_pkg::req_t req_i,
  output c8alu_pkg::rsp_t rsp_o
);

  logic [7:0]  t;
  logic [7:0]  s;
  logic [7:0]  a;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  dif9;
  logic [4:0]  hdif5;
  logic [8:0]  cdif9;
  logic [4:0]  hcdif5;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_adj;
  logic [7:0]  mask8;
  logic [7:0]  r8;
  c8alu_pkg::flags_t f;

  assign t = req_i.target[7:0];
  assign s = req_i.source[7:0];
  assign a = req_i.acc;

  assign sum9   = {1'b0, a} + {1'b0, s} + {8'd0, req_i.cin};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, s[3:0]} + {4'd0, req_i.cin};
  assign dif9   = {1'b0, a} - {1'b0, s} - {8'd0, req_i.cin};
  assign hdif5  = {1'b0, a[3:0]} - {1'b0, s[3:0]} - {4'd0, req_i.cin};
  assign cdif9  = {1'b0, a} - {1'b0, s};
  assign hcdif5 = {1'b0, a[3:0]} - {1'b0, s[3:0]};
  assign sum17  = {1'b0, req_i.target} + {1'b0, req_i.source};
  assign hsum13 = {1'b0, req_i.target[11:0]} + {1'b0, req_i.source[11:0]};
  assign mask8  = 8'd1 << req_i.bit_index;

  assign daa_lo = req_i.flags.n ? req_i.flags.h
                                : (req_i.flags.h || (a[3:0] > c8alu_pkg::NibbleMax));
  assign daa_hi = req_i.flags.n ? req_i.flags.c
                                : (req_i.flags.c || (a > c8alu_pkg::ByteBcdMax));
  assign daa_adj = {1'b0, daa_hi, daa_hi, 2'b00, daa_lo, daa_lo, 1'b0};

  always_comb begin
    f = req_i.flags;
    r8 = 8'd0;
    rsp_o.result = req_i.target;
    unique case (c8alu_pkg::op_e'(req_i.op))
      c8alu_pkg::OP_ADD8: begin
        r8 = sum9[7:0];
        f = '{z: r8 == 8'd0, n: 1'b0, h: hsum5[4], c: sum9[8]};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_SUB8: begin
        r8 = dif9[7:0];
        f = '{z: r8 == 8'd0, n: 1'b1, h: hdif5[4], c: dif9[8]};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_ADD16: begin
        f.n = 1'b0;
        f.h = hsum13[12];
        f.c = sum17[16];
        rsp_o.result = sum17[15:0];
      end
      c8alu_pkg::OP_RLC: begin
        r8 = {t[6:0], t[7]};
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: t[7]};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_RRC: begin
        r8 = {t[0], t[7:1]};
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: t[0]};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_RL: begin
        r8 = {t[6:0], req_i.flags.c};
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: t[7]};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_RR: begin
        r8 = {req_i.flags.c, t[7:1]};
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: t[0]};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_SLA: begin
        r8 = {t[6:0], 1'b0};
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: t[7]};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_SRA: begin
        r8 = {t[7], t[7:1]};
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: t[0]};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_SRL: begin
        r8 = {1'b0, t[7:1]};
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: t[0]};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_SWAP: begin
        r8 = {t[3:0], t[7:4]};
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_DEC8: begin
        r8 = t - 8'd1;
        f.z = (r8 == 8'd0);
        f.n = 1'b1;
        f.h = (t[3:0] == 4'h0);
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_DEC16: begin
        rsp_o.result = req_i.target - 16'd1;
      end
      c8alu_pkg::OP_INC8: begin
        r8 = t + 8'd1;
        f.z = (r8 == 8'd0);
        f.n = 1'b0;
        f.h = (t[3:0] == 4'hF);
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_INC16: begin
        rsp_o.result = req_i.target + 16'd1;
      end
      c8alu_pkg::OP_AND: begin
        r8 = a & s;
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b1, c: 1'b0};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_OR: begin
        r8 = a | s;
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_XOR: begin
        r8 = a ^ s;
        f = '{z: r8 == 8'd0, n: 1'b0, h: 1'b0, c: 1'b0};
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_CPL: begin
        r8 = ~a;
        f.n = 1'b1;
        f.h = 1'b1;
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_CP: begin
        f = '{z: cdif9[7:0] == 8'd0, n: 1'b1, h: hcdif5[4], c: cdif9[8]};
        rsp_o.result = {8'd0, a};
      end
      c8alu_pkg::OP_DAA: begin
        r8 = req_i.flags.n ? (a - daa_adj) : (a + daa_adj);
        f.z = (r8 == 8'd0);
        f.h = 1'b0;
        f.c = daa_hi;
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_SCF: begin
        f.n = 1'b0;
        f.h = 1'b0;
        f.c = 1'b1;
        rsp_o.result = {8'd0, a};
      end
      c8alu_pkg::OP_CCF: begin
        f.n = 1'b0;
        f.h = 1'b0;
        f.c = ~req_i.flags.c;
        rsp_o.result = {8'd0, a};
      end
      c8alu_pkg::OP_BIT: begin
        f.z = ((t & mask8) == 8'd0);
        f.n = 1'b0;
        f.h = 1'b1;
        rsp_o.result = {8'd0, t};
      end
      c8alu_pkg::OP_RES: begin
        r8 = t & ~mask8;
        rsp_o.result = {8'd0, r8};
      end
      c8alu_pkg::OP_SET: begin
        r8 = t | mask8;
        rsp_o.result = {8'd0, r8};
      end
      default: begin
        rsp_o.result = req_i.target;
      end
    endcase
    rsp_o.flags = f;
  end

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldStart   = 300;
  localparam int HoldLen     = 48;
  localparam int CalmStart   = 1000;
  localparam int CalmEnd     = 1400;
  localparam int QuietLimit  = 500;
  localparam int RandomItems = 1700;
  localparam int MaxReports  = 10;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [4:0]  op_i        = '0;
  logic [7:0]  acc_i       = '0;
  logic [15:0] target_i    = '0;
  logic [15:0] source_i    = '0;
  logic        cin_i       = 1'b0;
  logic [2:0]  bit_index_i = '0;
  logic        z_in_i      = 1'b0;
  logic        n_in_i      = 1'b0;
  logic        h_in_i      = 1'b0;
  logic        c_in_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] result_o;
  logic        z_out_o;
  logic        n_out_o;
  logic        h_out_o;
  logic        c_out_o;

  cpu8_alu_with_flags dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .acc_i,
    .target_i,
    .source_i,
    .cin_i,
    .bit_index_i,
    .z_in_i,
    .n_in_i,
    .h_in_i,
    .c_in_i,
    .out_valid_o,
    .out_stall_i,
    .result_o,
    .z_out_o,
    .n_out_o,
    .h_out_o,
    .c_out_o
  );

  c8alu_pkg::req_t op_q[$];
  c8alu_pkg::rsp_t alu_result_q[$];
  c8alu_pkg::req_t drv_beat;
  c8alu_pkg::rsp_t want;
  c8alu_pkg::rsp_t got;
  int              cyc;
  int              hold_left;
  int              quiet;
  int              errors;
  int              n_sent;
  int              n_checked;
  int              n_in_stalls;
  logic [31:0]     ops_seen;
  logic            calm;

  assign calm = (cyc >= CalmStart) && (cyc < CalmEnd);

  always #6 clk_i = ~clk_i;

  function automatic c8alu_pkg::rsp_t alu_expect(c8alu_pkg::req_t q);
    logic [7:0]        a;
    logic [7:0]        t;
    logic [7:0]        s;
    logic [7:0]        r8;
    logic [7:0]        adj;
    logic [8:0]        sum9;
    logic [4:0]        nib;
    logic [12:0]       low13;
    logic [16:0]       sum17;
    c8alu_pkg::flags_t f;
    c8alu_pkg::rsp_t   res;
    a = q.acc;
    t = q.target[7:0];
    s = q.source[7:0];
    f = q.flags;
    r8 = t;
    res.result = q.target;
    case (q.op)
      c8alu_pkg::OP_ADD8: begin
        sum9 = {1'b0, a} + {1'b0, s} + 9'(q.cin);
        nib  = {1'b0, a[3:0]} + {1'b0, s[3:0]} + 5'(q.cin);
        r8 = sum9[7:0];
        f.c = sum9[8];
        f.h = nib[4];
        f.n = 1'b0;
      end
      c8alu_pkg::OP_SUB8: begin
        sum9 = {1'b0, a} - {1'b0, s} - 9'(q.cin);
        nib  = {1'b0, a[3:0]} - {1'b0, s[3:0]} - 5'(q.cin);
        r8 = sum9[7:0];
        f.c = sum9[8];
        f.h = nib[4];
        f.n = 1'b1;
      end
      c8alu_pkg::OP_RLC: begin r8 = {t[6:0], t[7]}; f.c = t[7]; f.n = 1'b0; f.h = 1'b0; end
      c8alu_pkg::OP_RRC: begin r8 = {t[0], t[7:1]}; f.c = t[0]; f.n = 1'b0; f.h = 1'b0; end
      c8alu_pkg::OP_RL: begin
        r8 = {t[6:0], q.flags.c}; f.c = t[7]; f.n = 1'b0; f.h = 1'b0;
      end
      c8alu_pkg::OP_RR: begin
        r8 = {q.flags.c, t[7:1]}; f.c = t[0]; f.n = 1'b0; f.h = 1'b0;
      end
      c8alu_pkg::OP_SLA: begin r8 = {t[6:0], 1'b0}; f.c = t[7]; f.n = 1'b0; f.h = 1'b0; end
      c8alu_pkg::OP_SRA: begin r8 = {t[7], t[7:1]}; f.c = t[0]; f.n = 1'b0; f.h = 1'b0; end
      c8alu_pkg::OP_SRL: begin r8 = {1'b0, t[7:1]}; f.c = t[0]; f.n = 1'b0; f.h = 1'b0; end
      c8alu_pkg::OP_SWAP: begin
        r8 = {t[3:0], t[7:4]}; f.c = 1'b0; f.n = 1'b0; f.h = 1'b0;
      end
      c8alu_pkg::OP_DEC8: begin r8 = t - 8'd1; f.h = (t[3:0] == 4'h0); f.n = 1'b1; end
      c8alu_pkg::OP_INC8: begin r8 = t + 8'd1; f.h = (t[3:0] == 4'hF); f.n = 1'b0; end
      c8alu_pkg::OP_AND: begin r8 = a & s; f.n = 1'b0; f.h = 1'b1; f.c = 1'b0; end
      c8alu_pkg::OP_OR:  begin r8 = a | s; f.n = 1'b0; f.h = 1'b0; f.c = 1'b0; end
      c8alu_pkg::OP_XOR: begin r8 = a ^ s; f.n = 1'b0; f.h = 1'b0; f.c = 1'b0; end
      c8alu_pkg::OP_CPL: begin r8 = ~a; f.n = 1'b1; f.h = 1'b1; end
      c8alu_pkg::OP_CP: begin
        r8 = a;
        f.z = (a == s);
        f.n = 1'b1;
        f.h = (a[3:0] < s[3:0]);
        f.c = (a < s);
      end
      c8alu_pkg::OP_DAA: begin
        adj = 8'h00;
        if (q.flags.n) begin
          if (q.flags.h) adj = adj + 8'h06;
          if (q.flags.c) adj = adj + 8'h60;
          r8 = a - adj;
        end else begin
          if (q.flags.h || (a[3:0] > c8alu_pkg::NibbleMax)) adj = adj + 8'h06;
          if (q.flags.c || (a > c8alu_pkg::ByteBcdMax)) begin
            adj = adj + 8'h60;
            f.c = 1'b1;
          end
          r8 = a + adj;
        end
        f.h = 1'b0;
      end
      c8alu_pkg::OP_SCF: begin r8 = a; f.c = 1'b1; f.n = 1'b0; f.h = 1'b0; end
      c8alu_pkg::OP_CCF: begin r8 = a; f.c = ~q.flags.c; f.n = 1'b0; f.h = 1'b0; end
      c8alu_pkg::OP_BIT: begin
        r8 = t; f.z = ~t[q.bit_index]; f.n = 1'b0; f.h = 1'b1;
      end
      c8alu_pkg::OP_RES: r8 = t & ~(8'h01 << q.bit_index);
      c8alu_pkg::OP_SET: r8 = t | (8'h01 << q.bit_index);
      default: ;
    endcase
    case (q.op)
      c8alu_pkg::OP_ADD16: begin
        sum17 = {1'b0, q.target} + {1'b0, q.source};
        low13 = {1'b0, q.target[11:0]} + {1'b0, q.source[11:0]};
        res.result = sum17[15:0];
        f.h = low13[12];
        f.c = sum17[16];
        f.n = 1'b0;
      end
      c8alu_pkg::OP_INC16: res.result = q.target + 16'd1;
      c8alu_pkg::OP_DEC16: res.result = q.target - 16'd1;
      c8alu_pkg::OP_ADD8, c8alu_pkg::OP_SUB8, c8alu_pkg::OP_RLC, c8alu_pkg::OP_RRC,
      c8alu_pkg::OP_RL, c8alu_pkg::OP_RR, c8alu_pkg::OP_SLA, c8alu_pkg::OP_SRA,
      c8alu_pkg::OP_SRL, c8alu_pkg::OP_SWAP, c8alu_pkg::OP_DEC8, c8alu_pkg::OP_INC8,
      c8alu_pkg::OP_AND, c8alu_pkg::OP_OR, c8alu_pkg::OP_XOR, c8alu_pkg::OP_DAA: begin
        res.result = {8'h00, r8};
        f.z = (r8 == 8'h00);
      end
      c8alu_pkg::OP_CPL, c8alu_pkg::OP_CP, c8alu_pkg::OP_SCF, c8alu_pkg::OP_CCF,
      c8alu_pkg::OP_BIT, c8alu_pkg::OP_RES, c8alu_pkg::OP_SET:
        res.result = {8'h00, r8};
      default: ;
    endcase
    res.flags = f;
    return res;
  endfunction

  function automatic logic [7:0] corner_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0F;
      3: return 8'h10;
      4: return 8'h99;
      5: return 8'h9A;
      6: return 8'h80;
      default: return 8'h01;
    endcase
  endfunction

  function automatic c8alu_pkg::req_t random_alu_op();
    c8alu_pkg::req_t q;
    if ($urandom_range(19) == 0) q.op = 5'($urandom_range(c8alu_pkg::OP_SET + 1, 5'h1F));
    else q.op = 5'($urandom_range(c8alu_pkg::OP_SET));
    q.acc       = 8'($urandom);
    q.target    = 16'($urandom);
    q.source    = 16'($urandom);
    q.cin       = 1'($urandom);
    q.bit_index = 3'($urandom);
    q.flags     = c8alu_pkg::flags_t'(4'($urandom));
    if ($urandom_range(5) == 0) q.acc = corner_byte();
    if ($urandom_range(5) == 0) q.target[7:0] = corner_byte();
    if ($urandom_range(5) == 0) q.source[7:0] = corner_byte();
    if ($urandom_range(7) == 0) q.source[7:0] = q.acc;
    if ($urandom_range(11) == 0) q.target = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(11) == 0) q.target[11:0] = 12'hFFF;
    return q;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        alu_result_q.push_back(alu_expect(drv_beat));
        ops_seen[drv_beat.op] = 1'b1;
        n_sent++;
      end
      if (in_valid_i && in_stall_o) n_in_stalls++;
      if (!in_valid_i || !in_stall_o) begin
        if (op_q.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
          drv_beat = op_q.pop_front();
          op_i        <= drv_beat.op;
          acc_i       <= drv_beat.acc;
          target_i    <= drv_beat.target;
          source_i    <= drv_beat.source;
          cin_i       <= drv_beat.cin;
          bit_index_i <= drv_beat.bit_index;
          z_in_i      <= drv_beat.flags.z;
          n_in_i      <= drv_beat.flags.n;
          h_in_i      <= drv_beat.flags.h;
          c_in_i      <= drv_beat.flags.c;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      cyc         <= 0;
      hold_left   <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc == HoldStart) begin
        hold_left   <= HoldLen;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 13);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {result_o, z_out_o, n_out_o, h_out_o, c_out_o};
      if (alu_result_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected result beat: %04h z%b n%b h%b c%b",
                   got.result, got.flags.z, got.flags.n, got.flags.h, got.flags.c);
      end else begin
        want = alu_result_q.pop_front();
        n_checked++;
        if (got.result !== want.result || got.flags.z !== want.flags.z ||
            got.flags.n !== want.flags.n || got.flags.h !== want.flags.h ||
            got.flags.c !== want.flags.c) begin
          errors++;
          if (errors <= MaxReports)
            $display("mismatch %0d: expected %04h z%b n%b h%b c%b, got %04h z%b n%b h%b c%b",
                     n_checked, want.result, want.flags.z, want.flags.n, want.flags.h,
                     want.flags.c, got.result, got.flags.z, got.flags.n, got.flags.h,
                     got.flags.c);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("timeout: no beat moved for %0d cycles", QuietLimit);
        $display("tb NOT OK");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    c8alu_pkg::req_t q;
    errors      = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_in_stalls = 0;
    quiet       = 0;
    ops_seen    = '0;

    // every code, operands and flags at all-zeros or all-ones
    for (int k = 0; k < 32; k++) begin
      q.op        = 5'(k);
      q.acc       = {8{k[0]}};
      q.target    = {16{k[0]}};
      q.source    = k[1] ? {16{k[0]}} : ~{16{k[0]}};
      q.cin       = k[0];
      q.bit_index = 3'(k);
      q.flags     = {4{k[0]}};
      op_q.push_back(q);
    end
    q = '0;
    q.op = c8alu_pkg::OP_DAA;
    q.acc = 8'h9A;
    op_q.push_back(q);
    q.flags = 4'b0111;
    q.acc = 8'h00;
    op_q.push_back(q);
    q = '0;
    q.op = c8alu_pkg::OP_ADD16;
    q.target = 16'h0FFF;
    q.source = 16'h0001;
    op_q.push_back(q);
    q = '0;
    q.op = c8alu_pkg::OP_SUB8;
    q.acc = 8'h10;
    q.source = 16'h000F;
    q.cin = 1'b1;
    op_q.push_back(q);

    for (int k = 0; k < RandomItems; k++) op_q.push_back(random_alu_op());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (op_q.size() != 0 || in_valid_i || alu_result_q.size() != 0);
    repeat (8) @(posedge clk_i);

    if (alu_result_q.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", alu_result_q.size());
    end
    $display("sent %0d operations over %0d of 32 op codes, checked %0d results",
             n_sent, $countones(ops_seen), n_checked);
    $display("input held off for %0d cycles, %0d mismatches", n_in_stalls, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
